>>> rtl/dpfb_pkg.sv
// Package for the dual page framebuffer engine.
// Holds request codes, the internal operation type and the command record.
// No dependencies.
package dpfb_pkg;

	localparam logic [3:0] REQ_WR_BYTE = 4'd0;
	localparam logic [3:0] REQ_RD_BYTE = 4'd1;
	localparam logic [3:0] REQ_WR_PIX  = 4'd2;
	localparam logic [3:0] REQ_RD_PIX  = 4'd3;
	localparam logic [3:0] REQ_COPY    = 4'd4;
	localparam logic [3:0] REQ_CLR_SCR = 4'd5;
	localparam logic [3:0] REQ_OR      = 4'd6;
	localparam logic [3:0] REQ_ANDNOT  = 4'd7;
	localparam logic [3:0] REQ_FILL    = 4'd8;

	localparam logic [7:0] PIX_ONE = 8'h01;

	typedef enum logic [3:0] {
		OP_WR_BYTE,
		OP_RD_BYTE,
		OP_WR_PIX,
		OP_RD_PIX,
		OP_COPY,
		OP_CLR_SCR,
		OP_OR,
		OP_ANDNOT,
		OP_FILL,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t        op;
		logic       target;
		logic       oor;
		logic [3:0] page;
		logic [7:0] x;
		logic [2:0] bit_pos;
		logic [7:0] data;
		logic       pix_val;
	} cmd_t;

endpackage

>>> rtl/dpfb_ram.sv
// Generic simple dual port RAM: one write port, one read port, registered read.
// No dependencies.
module dpfb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/dpfb_queue.sv
// Two entry command queue between the front and back parts.
// Depends on dpfb_pkg for the command record.
module dpfb_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  dpfb_pkg::cmd_t push_cmd,
	input  logic          pop,
	output dpfb_pkg::cmd_t head,
	output logic          head_valid,
	output logic          full
);

	dpfb_pkg::cmd_t ent_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_cmd;
		end
	end

	assign head       = ent_q[rd_ptr_q];
	assign head_valid = (cnt_q != 2'd0);
	assign full       = (cnt_q == 2'd2);

endmodule

>>> rtl/dpfb_front.sv
// Front part: target register, request acceptance and classification.
// Depends on dpfb_pkg for request codes and the command record.
module dpfb_front #(
	parameter int PAGES   = 8,
	parameter int COLUMNS = 128
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [3:0]     req_type,
	input  logic [7:0]     x_pos,
	input  logic [2:0]     page,
	input  logic [6:0]     pixel_y,
	input  logic [7:0]     data_byte,
	input  logic           pixel_value,
	input  logic           cfg_valid,
	input  logic           cfg_data,
	input  logic           q_full,
	input  logic           clearing,
	output logic           busy,
	output logic           push,
	output dpfb_pkg::cmd_t cmd
);

	logic tgt_q;
	logic x_oor;
	logic page_oor;
	logic y_oor;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_q <= 1'b1;
		end else if (cfg_valid) begin
			tgt_q <= cfg_data;
		end
	end

	assign x_oor    = ({1'b0, x_pos} >= 9'(COLUMNS));
	assign page_oor = ({2'b0, page} >= 5'(PAGES));
	assign y_oor    = ({1'b0, pixel_y} >= 8'(8 * PAGES));

	always_comb begin
		cmd         = '0;
		cmd.op      = dpfb_pkg::OP_NOP;
		cmd.target  = tgt_q;
		cmd.x       = x_pos;
		cmd.data    = data_byte;
		cmd.pix_val = pixel_value;
		cmd.bit_pos = pixel_y[2:0];
		cmd.page    = {1'b0, page};
		case (req_type)
			dpfb_pkg::REQ_WR_BYTE: begin
				cmd.op  = dpfb_pkg::OP_WR_BYTE;
				cmd.oor = x_oor || page_oor;
			end
			dpfb_pkg::REQ_RD_BYTE: begin
				cmd.op  = dpfb_pkg::OP_RD_BYTE;
				cmd.oor = x_oor || page_oor;
			end
			dpfb_pkg::REQ_WR_PIX: begin
				cmd.op   = dpfb_pkg::OP_WR_PIX;
				cmd.oor  = x_oor || y_oor;
				cmd.page = pixel_y[6:3];
			end
			dpfb_pkg::REQ_RD_PIX: begin
				cmd.op   = dpfb_pkg::OP_RD_PIX;
				cmd.oor  = x_oor || y_oor;
				cmd.page = pixel_y[6:3];
			end
			dpfb_pkg::REQ_COPY:    cmd.op = dpfb_pkg::OP_COPY;
			dpfb_pkg::REQ_CLR_SCR: cmd.op = dpfb_pkg::OP_CLR_SCR;
			dpfb_pkg::REQ_OR:      cmd.op = dpfb_pkg::OP_OR;
			dpfb_pkg::REQ_ANDNOT:  cmd.op = dpfb_pkg::OP_ANDNOT;
			dpfb_pkg::REQ_FILL:    cmd.op = dpfb_pkg::OP_FILL;
			default:               cmd.op = dpfb_pkg::OP_NOP;
		endcase
	end

	assign busy = q_full || clearing;
	assign push = start && !busy;

endmodule

>>> rtl/dpfb_back.sv
// Back part: executes queued commands on the screen and scratch stores.
// Depends on dpfb_pkg; drives the two store RAMs instantiated at the top level.
module dpfb_back #(
	parameter int PAGES   = 8,
	parameter int COLUMNS = 128
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  dpfb_pkg::cmd_t                       head,
	input  logic                                 head_valid,
	output logic                                 pop,
	output logic                                 clearing,
	output logic                                 scn_we,
	output logic                                 scr_we,
	output logic [$clog2(PAGES*COLUMNS)-1:0]     waddr,
	output logic [7:0]                           wdata,
	output logic [$clog2(PAGES*COLUMNS)-1:0]     raddr,
	input  logic [7:0]                           scn_rd,
	input  logic [7:0]                           scr_rd,
	output logic                                 done,
	output logic [7:0]                           read_data,
	output logic                                 out_of_range
);

	localparam int DEPTH  = PAGES * COLUMNS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RMW,
		ST_BULK
	} state_t;

	state_t         state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_m1;
	dpfb_pkg::cmd_t cur_q;
	logic [ADDR_W-1:0] addr_q;
	logic [ADDR_W-1:0] head_addr;
	logic [7:0]     rd_sel;
	logic [7:0]     pix_mask;
	logic [7:0]     pix_new;
	logic           done_q;
	logic [7:0]     read_data_q;
	logic           oor_q;

	assign head_addr = ADDR_W'(32'(head.page) * COLUMNS + 32'(head.x));
	assign cnt_m1    = cnt_q - CNT_W'(1);
	assign rd_sel    = cur_q.target ? scn_rd : scr_rd;
	assign pix_mask  = dpfb_pkg::PIX_ONE << cur_q.bit_pos;
	assign pix_new   = cur_q.pix_val ? (rd_sel | pix_mask) : (rd_sel & ~pix_mask);
	assign pop       = (state_q == ST_IDLE) && head_valid;
	assign clearing  = (state_q == ST_CLEAR);

	always_comb begin
		scn_we = 1'b0;
		scr_we = 1'b0;
		waddr  = '0;
		wdata  = '0;
		raddr  = head_addr;
		case (state_q)
			ST_IDLE: begin
				if (head_valid && head.op == dpfb_pkg::OP_WR_BYTE && !head.oor) begin
					scn_we = head.target;
					scr_we = !head.target;
					waddr  = head_addr;
					wdata  = head.data;
				end
			end
			ST_RMW: begin
				if (cur_q.op == dpfb_pkg::OP_WR_PIX) begin
					scn_we = cur_q.target;
					scr_we = !cur_q.target;
					waddr  = addr_q;
					wdata  = pix_new;
				end
			end
			ST_BULK: begin
				raddr = cnt_q[ADDR_W-1:0];
				waddr = cnt_m1[ADDR_W-1:0];
				if (cnt_q != '0) begin
					case (cur_q.op)
						dpfb_pkg::OP_COPY: begin
							scn_we = 1'b1;
							wdata  = scr_rd;
						end
						dpfb_pkg::OP_OR: begin
							scn_we = 1'b1;
							wdata  = scn_rd | scr_rd;
						end
						dpfb_pkg::OP_ANDNOT: begin
							scn_we = 1'b1;
							wdata  = scn_rd & ~scr_rd;
						end
						dpfb_pkg::OP_FILL: begin
							scn_we = 1'b1;
							wdata  = cur_q.data;
						end
						dpfb_pkg::OP_CLR_SCR: begin
							scr_we = 1'b1;
							wdata  = '0;
						end
						default: begin
							scn_we = 1'b0;
						end
					endcase
				end
			end
			ST_CLEAR: begin
				scn_we = 1'b1;
				scr_we = 1'b1;
				waddr  = cnt_q[ADDR_W-1:0];
				wdata  = '0;
			end
			default: begin
				scn_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cnt_q       <= '0;
			done_q      <= 1'b0;
			read_data_q <= '0;
			oor_q       <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					if (cnt_q == CNT_W'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_IDLE: begin
					if (head_valid) begin
						cnt_q <= '0;
						if (head.oor || head.op == dpfb_pkg::OP_NOP ||
								head.op == dpfb_pkg::OP_WR_BYTE) begin
							done_q      <= 1'b1;
							read_data_q <= '0;
							oor_q       <= head.oor;
						end else if (head.op inside {dpfb_pkg::OP_RD_BYTE,
								dpfb_pkg::OP_WR_PIX, dpfb_pkg::OP_RD_PIX}) begin
							state_q <= ST_RMW;
						end else begin
							state_q <= ST_BULK;
						end
					end
				end
				ST_RMW: begin
					done_q  <= 1'b1;
					oor_q   <= 1'b0;
					state_q <= ST_IDLE;
					case (cur_q.op)
						dpfb_pkg::OP_RD_BYTE: read_data_q <= rd_sel;
						dpfb_pkg::OP_RD_PIX:  read_data_q <= {7'b0, rd_sel[cur_q.bit_pos]};
						default:              read_data_q <= '0;
					endcase
				end
				ST_BULK: begin
					if (cnt_q == CNT_W'(DEPTH)) begin
						done_q      <= 1'b1;
						read_data_q <= '0;
						oor_q       <= 1'b0;
						state_q     <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q  <= head;
			addr_q <= head_addr;
		end
	end

	assign done         = done_q;
	assign read_data    = read_data_q;
	assign out_of_range = oor_q;

endmodule

>>> rtl/dual_page_framebuffer_engine_core.sv
// Dual page framebuffer engine, top level: front, command queue, back, two store RAMs.
// Byte writes and skipped requests finish in the idle state; byte reads and pixel requests pass
// through the read-modify-write state; bulk requests sweep every store entry (one store entry a cycle).
// Requests wait in the two entry command queue; the back part executes one command at a time.
// After reset both stores are cleared with busy high; done cannot stall.
// Depends on dpfb_pkg, dpfb_front, dpfb_queue, dpfb_back and dpfb_ram.
module dual_page_framebuffer_engine_core #(
	parameter int PAGES   = 8,
	parameter int COLUMNS = 128
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [3:0] req_type,
	input  logic [7:0] x_pos,
	input  logic [2:0] page,
	input  logic [6:0] pixel_y,
	input  logic [7:0] data_byte,
	input  logic       pixel_value,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data,
	output logic       done,
	output logic [7:0] read_data,
	output logic       out_of_range
);

	localparam int DEPTH  = PAGES * COLUMNS;
	localparam int ADDR_W = $clog2(DEPTH);

	dpfb_pkg::cmd_t    push_cmd;
	dpfb_pkg::cmd_t    head;
	logic              push;
	logic              pop;
	logic              head_valid;
	logic              q_full;
	logic              clearing;
	logic              scn_we;
	logic              scr_we;
	logic [ADDR_W-1:0] waddr;
	logic [7:0]        wdata;
	logic [ADDR_W-1:0] raddr;
	logic [7:0]        scn_rd;
	logic [7:0]        scr_rd;

	assign cfg_ready = 1'b1;

	dpfb_front #(
		.PAGES   (PAGES),
		.COLUMNS (COLUMNS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.req_type    (req_type),
		.x_pos       (x_pos),
		.page        (page),
		.pixel_y     (pixel_y),
		.data_byte   (data_byte),
		.pixel_value (pixel_value),
		.cfg_valid   (cfg_valid),
		.cfg_data    (cfg_data),
		.q_full      (q_full),
		.clearing    (clearing),
		.busy        (busy),
		.push        (push),
		.cmd         (push_cmd)
	);

	dpfb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid),
		.full       (q_full)
	);

	dpfb_back #(
		.PAGES   (PAGES),
		.COLUMNS (COLUMNS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.head_valid   (head_valid),
		.pop          (pop),
		.clearing     (clearing),
		.scn_we       (scn_we),
		.scr_we       (scr_we),
		.waddr        (waddr),
		.wdata        (wdata),
		.raddr        (raddr),
		.scn_rd       (scn_rd),
		.scr_rd       (scr_rd),
		.done         (done),
		.read_data    (read_data),
		.out_of_range (out_of_range)
	);

	dpfb_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_screen_ram (
		.clk   (clk),
		.we    (scn_we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (scn_rd)
	);

	dpfb_ram #(
		.WIDTH (8),
		.DEPTH (DEPTH)
	) u_scratch_ram (
		.clk   (clk),
		.we    (scr_we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (scr_rd)
	);

`ifndef SYNTH
	a_busy_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> busy)
		else $error("start taken during store clearing");

	a_no_done_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !done)
		else $error("result issued during store clearing");

	a_oor_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && out_of_range) |-> (read_data == 8'h00))
		else $error("skipped request returned nonzero data");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("command queue popped while empty");
`endif

endmodule

>>> tb/dual_page_framebuffer_engine_core_tb.sv
// Testbench for dual_page_framebuffer_engine_core: byte, pixel and bulk requests on both stores.
// A shadow copy of the two stores predicts every reply; depends on dpfb_pkg and the core RTL.
`timescale 1ns / 1ps

module dual_page_framebuffer_engine_core_tb;

	localparam int STORE_PAGES   = 8;
	localparam int STORE_COLS    = 128;
	localparam int STORE_SIZE    = STORE_PAGES * STORE_COLS;
	localparam int PIXEL_ROWS    = STORE_PAGES * 8;
	localparam logic [3:0] REQ_MAX_CODE = 4'hF;
	localparam int SETTLE_CYCLES = 16;
	localparam int PHASE_ITEMS   = 300;
	localparam int PHASE_COUNT   = 6;

	typedef struct packed {
		logic [3:0] kind;
		logic [7:0] x;
		logic [2:0] pg;
		logic [6:0] y;
		logic [7:0] data;
		logic       pv;
	} fb_request_t;

	typedef struct packed {
		logic [3:0] kind;
		logic [7:0] rd;
		logic       oor;
	} fb_reply_t;

	class framebuffer_shadow;
		logic [7:0] screen_mem [STORE_SIZE];
		logic [7:0] scratch_mem [STORE_SIZE];
		logic       on_screen;
		fb_reply_t  expected_replies [$];
		int         errors;

		function new();
			foreach (screen_mem[i]) begin
				screen_mem[i]  = '0;
				scratch_mem[i] = '0;
			end
			on_screen = 1'b1;
			errors = 0;
		endfunction

		function void set_target(logic v);
			on_screen = v;
		endfunction

		function int outstanding();
			return expected_replies.size();
		endfunction

		function logic [7:0] read_entry(int idx);
			return on_screen ? screen_mem[idx] : scratch_mem[idx];
		endfunction

		function void write_entry(int idx, logic [7:0] v);
			if (on_screen)
				screen_mem[idx] = v;
			else
				scratch_mem[idx] = v;
		endfunction

		function void apply_request(fb_request_t r);
			fb_reply_t  res;
			int         idx;
			logic [7:0] mask;
			logic [7:0] entry;
			res = '0;
			res.kind = r.kind;
			case (r.kind)
				dpfb_pkg::REQ_WR_BYTE, dpfb_pkg::REQ_RD_BYTE: begin
					if (int'(r.x) >= STORE_COLS || int'(r.pg) >= STORE_PAGES) begin
						res.oor = 1'b1;
					end else begin
						idx = int'(r.pg) * STORE_COLS + int'(r.x);
						if (r.kind == dpfb_pkg::REQ_WR_BYTE)
							write_entry(idx, r.data);
						else
							res.rd = read_entry(idx);
					end
				end
				dpfb_pkg::REQ_WR_PIX, dpfb_pkg::REQ_RD_PIX: begin
					if (int'(r.x) >= STORE_COLS || int'(r.y) >= PIXEL_ROWS) begin
						res.oor = 1'b1;
					end else begin
						idx = int'(r.y[6:3]) * STORE_COLS + int'(r.x);
						mask = dpfb_pkg::PIX_ONE << r.y[2:0];
						entry = read_entry(idx);
						if (r.kind == dpfb_pkg::REQ_WR_PIX)
							write_entry(idx, r.pv ? (entry | mask) : (entry & ~mask));
						else
							res.rd = (entry >> r.y[2:0]) & dpfb_pkg::PIX_ONE;
					end
				end
				dpfb_pkg::REQ_COPY: begin
					foreach (screen_mem[i]) screen_mem[i] = scratch_mem[i];
				end
				dpfb_pkg::REQ_CLR_SCR: begin
					foreach (scratch_mem[i]) scratch_mem[i] = '0;
				end
				dpfb_pkg::REQ_OR: begin
					foreach (screen_mem[i]) screen_mem[i] = screen_mem[i] | scratch_mem[i];
				end
				dpfb_pkg::REQ_ANDNOT: begin
					foreach (screen_mem[i]) screen_mem[i] = screen_mem[i] & ~scratch_mem[i];
				end
				dpfb_pkg::REQ_FILL: begin
					foreach (screen_mem[i]) screen_mem[i] = r.data;
				end
				default: begin
				end
			endcase
			expected_replies.push_back(res);
		endfunction

		task report_mismatch(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_reply(logic [7:0] rd, logic oor);
			fb_reply_t want;
			if (expected_replies.size() == 0) begin
				report_mismatch($sformatf("reply with none pending: read_data=%0h oor=%0b", rd, oor));
			end else begin
				want = expected_replies.pop_front();
				if (rd !== want.rd)
					report_mismatch($sformatf("req %0d read_data got %0h want %0h",
						want.kind, rd, want.rd));
				if (oor !== want.oor)
					report_mismatch($sformatf("req %0d out_of_range got %0b want %0b",
						want.kind, oor, want.oor));
			end
		endtask
	endclass

	logic       clk = 1'b0;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic [3:0] req_type;
	logic [7:0] x_pos;
	logic [2:0] page;
	logic [6:0] pixel_y;
	logic [7:0] data_byte;
	logic       pixel_value;
	logic       cfg_valid;
	logic       cfg_ready;
	logic       cfg_data;
	logic       done;
	logic [7:0] read_data;
	logic       out_of_range;

	framebuffer_shadow shadow;

	dual_page_framebuffer_engine_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req_type     (req_type),
		.x_pos        (x_pos),
		.page         (page),
		.pixel_y      (pixel_y),
		.data_byte    (data_byte),
		.pixel_value  (pixel_value),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.done         (done),
		.read_data    (read_data),
		.out_of_range (out_of_range)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && done)
			shadow.check_reply(read_data, out_of_range);
	end

	function automatic fb_request_t random_request();
		fb_request_t r;
		int          sel;
		int          zone;
		r.kind = 4'($urandom);
		r.x    = 8'($urandom);
		r.pg   = 3'($urandom);
		r.y    = 7'($urandom);
		r.data = 8'($urandom);
		r.pv   = 1'($urandom);
		sel = $urandom_range(0, 99);
		if (sel < 24)
			r.kind = dpfb_pkg::REQ_WR_BYTE;
		else if (sel < 44)
			r.kind = dpfb_pkg::REQ_RD_BYTE;
		else if (sel < 68)
			r.kind = dpfb_pkg::REQ_WR_PIX;
		else if (sel < 92)
			r.kind = dpfb_pkg::REQ_RD_PIX;
		else if (sel < 97)
			r.kind = dpfb_pkg::REQ_COPY + 4'($urandom_range(0,
				int'(dpfb_pkg::REQ_FILL - dpfb_pkg::REQ_COPY)));
		else
			r.kind = 4'($urandom_range(int'(dpfb_pkg::REQ_FILL) + 1, int'(REQ_MAX_CODE)));
		zone = $urandom_range(0, 99);
		if (zone < 12)
			r.x = 8'($urandom_range(STORE_COLS, 255));
		else if (zone < 55)
			r.x = 8'($urandom_range(0, 15));
		else
			r.x = 8'($urandom_range(0, STORE_COLS - 1));
		if ($urandom_range(0, 99) < 12)
			r.y = 7'($urandom_range(PIXEL_ROWS, 127));
		else
			r.y = 7'($urandom_range(0, PIXEL_ROWS - 1));
		return r;
	endfunction

	task automatic issue(input fb_request_t r);
		@(negedge clk);
		start       <= 1'b1;
		req_type    <= r.kind;
		x_pos       <= r.x;
		page        <= r.pg;
		pixel_y     <= r.y;
		data_byte   <= r.data;
		pixel_value <= r.pv;
		do @(posedge clk); while (busy);
		shadow.apply_request(r);
	endtask

	task automatic issue_fields(input logic [3:0] kind, input logic [7:0] x, input logic [2:0] pg,
		input logic [6:0] y, input logic [7:0] data, input logic pv);
		fb_request_t r;
		r = '{kind: kind, x: x, pg: pg, y: y, data: data, pv: pv};
		issue(r);
	endtask

	task automatic idle_gap(input bit allow);
		int n;
		int roll;
		n = 0;
		if (allow) begin
			roll = $urandom_range(0, 99);
			if (roll < 60)
				n = 0;
			else if (roll < 90)
				n = $urandom_range(1, 3);
			else
				n = $urandom_range(4, 40);
		end
		if (n > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (shadow.outstanding() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_target(input logic v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		shadow.set_target(v);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		#100ms;
		$display("status: fail");
		$finish;
	end

	initial begin
		int phase;
		shadow = new();
		arst_n      = 1'b0;
		start       = 1'b0;
		req_type    = dpfb_pkg::REQ_WR_BYTE;
		x_pos       = '0;
		page        = '0;
		pixel_y     = '0;
		data_byte   = '0;
		pixel_value = 1'b0;
		cfg_valid   = 1'b0;
		cfg_data    = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_target(1'b1);
		issue_fields(dpfb_pkg::REQ_WR_BYTE, 8'd0, 3'd0, 7'd0, 8'hFF, 1'b0);
		issue_fields(dpfb_pkg::REQ_WR_BYTE, 8'd127, 3'd7, 7'd0, 8'h80, 1'b1);
		issue_fields(dpfb_pkg::REQ_RD_BYTE, 8'd0, 3'd0, 7'd0, 8'h00, 1'b0);
		idle_gap(1'b1);
		issue_fields(dpfb_pkg::REQ_RD_BYTE, 8'd127, 3'd7, 7'd127, 8'h00, 1'b0);
		issue_fields(dpfb_pkg::REQ_WR_BYTE, 8'd128, 3'd2, 7'd0, 8'h55, 1'b0);
		issue_fields(dpfb_pkg::REQ_RD_BYTE, 8'd255, 3'd7, 7'd0, 8'hFF, 1'b1);
		issue_fields(dpfb_pkg::REQ_WR_PIX, 8'd5, 3'd0, 7'd63, 8'h00, 1'b1);
		issue_fields(dpfb_pkg::REQ_RD_PIX, 8'd5, 3'd0, 7'd63, 8'h00, 1'b0);
		issue_fields(dpfb_pkg::REQ_WR_PIX, 8'd127, 3'd0, 7'd0, 8'hFF, 1'b0);
		issue_fields(dpfb_pkg::REQ_RD_PIX, 8'd127, 3'd0, 7'd0, 8'h00, 1'b0);
		issue_fields(dpfb_pkg::REQ_WR_PIX, 8'd3, 3'd0, 7'd64, 8'h00, 1'b1);
		issue_fields(dpfb_pkg::REQ_RD_PIX, 8'd255, 3'd0, 7'd127, 8'h00, 1'b1);
		issue_fields(dpfb_pkg::REQ_RD_PIX, 8'd128, 3'd0, 7'd0, 8'h00, 1'b0);
		drain();

		write_target(1'b0);
		issue_fields(dpfb_pkg::REQ_WR_BYTE, 8'd64, 3'd3, 7'd0, 8'hA5, 1'b0);
		issue_fields(dpfb_pkg::REQ_WR_PIX, 8'd10, 3'd0, 7'd10, 8'h00, 1'b1);
		issue_fields(dpfb_pkg::REQ_OR, 8'd0, 3'd0, 7'd0, 8'h00, 1'b0);
		issue_fields(dpfb_pkg::REQ_ANDNOT, 8'd0, 3'd0, 7'd0, 8'h00, 1'b0);
		issue_fields(dpfb_pkg::REQ_COPY, 8'd0, 3'd0, 7'd0, 8'h00, 1'b0);
		issue_fields(dpfb_pkg::REQ_CLR_SCR, 8'd0, 3'd0, 7'd0, 8'h00, 1'b0);
		issue_fields(dpfb_pkg::REQ_RD_BYTE, 8'd64, 3'd3, 7'd0, 8'h00, 1'b0);
		issue_fields(dpfb_pkg::REQ_FILL, 8'd0, 3'd0, 7'd0, 8'h3C, 1'b0);
		issue_fields(dpfb_pkg::REQ_FILL + 4'd1, 8'hFF, 3'd7, 7'd127, 8'hFF, 1'b1);
		issue_fields(REQ_MAX_CODE, 8'h00, 3'd0, 7'd0, 8'h00, 1'b0);
		drain();

		for (phase = 0; phase < PHASE_COUNT; phase++) begin
			if (phase < PHASE_COUNT - 2)
				write_target(phase[0] ? 1'b0 : 1'b1);
			else
				write_target(1'($urandom_range(0, 1)));
			repeat (PHASE_ITEMS) begin
				issue(random_request());
				idle_gap(phase % 3 != 2);
			end
			drain();
		end

		if (shadow.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

>>> sim.f
rtl/dpfb_pkg.sv
rtl/dpfb_ram.sv
rtl/dpfb_queue.sv
rtl/dpfb_front.sv
rtl/dpfb_back.sv
rtl/dual_page_framebuffer_engine_core.sv
tb/dual_page_framebuffer_engine_core_tb.sv
